// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and codes for the text console cell writer: command codes,
// classified operation codes and the fixed cell constants.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int OP_W   = 3;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [OP_W-1:0]   op_t;

    localparam cmd_t CMD_PUT   = 2'd0;
    localparam cmd_t CMD_BKSP  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;
    localparam cmd_t CMD_READ  = 2'd3;

    localparam op_t OP_PUT      = 3'd0;
    localparam op_t OP_NEWLINE  = 3'd1;
    localparam op_t OP_BKSP     = 3'd2;
    localparam op_t OP_CLEAR    = 3'd3;
    localparam op_t OP_READ     = 3'd4;
    localparam op_t OP_READ_OOR = 3'd5;

    localparam char_t NEWLINE_CODE = 8'h0A;
    localparam char_t BLANK_CODE   = 8'h20;
    localparam attr_t RESET_ATTR   = 8'h0F;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hdl/tccw_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tccw_queue.sv =====
// ----------------------------------------------------------------------------
// tccw_queue
// Short flip-flop FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module tccw_queue #(
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] pop_data
);

    import tccw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/tccw_front.sv =====
// ----------------------------------------------------------------------------
// tccw_front
// Input side: accept commands, classify them into operations and compute the
// cell address of a read.
// ----------------------------------------------------------------------------
module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  tccw_pkg::cmd_t                               cmd,
    input  tccw_pkg::char_t                              char_code,
    input  logic [$clog2(ROWS)-1:0]                      read_row,
    input  logic [$clog2(COLUMNS)-1:0]                   read_col,
    input  logic                                         init_busy,
    input  logic                                         q_full,
    output logic                                         q_push,
    output logic [tccw_pkg::OP_W+tccw_pkg::CHAR_W+$clog2(ROWS*COLUMNS)-1:0] q_data
);

    import tccw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic              in_range;

    assign in_range = ({1'b0, read_row} < (ROW_W + 1)'(ROWS))
                   && ({1'b0, read_col} < (COL_W + 1)'(COLUMNS));
    assign addr     = ADDR_W'(read_row) * ADDR_W'(COLUMNS) + ADDR_W'(read_col);

    always_comb
    begin
        case (cmd)
            CMD_PUT:   op = (char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            CMD_BKSP:  op = OP_BKSP;
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = in_range ? OP_READ : OP_READ_OOR;
            default:   op = OP_READ_OOR;
        endcase
    end

    assign in_stall = q_full || init_busy;
    assign q_push   = in_valid && !in_stall;
    assign q_data   = {op, char_code, addr};

endmodule

// ===== hdl/tccw_back.sv =====
// ----------------------------------------------------------------------------
// tccw_back
// Execution side: cursor, attribute register, cell RAM sequencer (write,
// read, scroll copy, blank fill) and the result register.
// ----------------------------------------------------------------------------
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  tccw_pkg::attr_t                              cfg_wdata,
    input  logic                                         q_not_empty,
    input  logic [tccw_pkg::OP_W+tccw_pkg::CHAR_W+$clog2(ROWS*COLUMNS)-1:0] q_data,
    output logic                                         q_pop,
    output logic                                         init_busy,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [$clog2(ROWS)-1:0]                      cursor_row_out,
    output logic [$clog2(COLUMNS)-1:0]                   cursor_col_out,
    output tccw_pkg::cell_t                              cell_value
);

    import tccw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY   = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [3:0] S_INIT       = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_EXEC       = 4'd2;
    localparam logic [3:0] S_BLANK      = 4'd3;
    localparam logic [3:0] S_RDWAIT     = 4'd4;
    localparam logic [3:0] S_SCROLL     = 4'd5;
    localparam logic [3:0] S_SCROLL_END = 4'd6;
    localparam logic [3:0] S_FILL       = 4'd7;
    localparam logic [3:0] S_DONE       = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    attr_t             attr_reg, attr_next;
    op_t               op_reg, op_next;

    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    char_t             char_reg, char_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    cell_t             cell_reg, cell_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    cell_t             out_cell_reg, out_cell_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    cell_t             ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    cell_t             ram_rdata;
    logic [ADDR_W-1:0] cur_addr;
    logic              out_free;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign init_busy = (state_reg == S_INIT);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        attr_next      = cfg_we ? cfg_wdata : attr_reg;
        op_next        = op_reg;
        wr_addr_next   = wr_addr_reg;
        char_next      = char_reg;
        addr_next      = addr_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_cell_next  = out_cell_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = {attr_reg, BLANK_CODE};
        ram_raddr      = addr_reg;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = {RESET_ATTR, BLANK_CODE};
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    {op_next, char_next, addr_next} = q_data;
                    cell_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_PUT, OP_NEWLINE:
                    begin
                        if (op_reg == OP_PUT)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {attr_reg, char_reg};
                        end
                        if (op_reg == OP_PUT && col_reg != COL_W'(COLUMNS - 1))
                        begin
                            col_next   = col_reg + 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            col_next = '0;
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                cnt_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                state_next = S_DONE;
                            end
                        end
                    end
                    OP_BKSP:
                    begin
                        if (row_reg == '0 && col_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (col_reg == '0)
                            begin
                                row_next = row_reg - 1'b1;
                                col_next = COL_W'(COLUMNS - 1);
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            state_next = S_BLANK;
                        end
                    end
                    OP_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                    OP_READ:
                    begin
                        state_next = S_RDWAIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_BLANK:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end
            S_RDWAIT:
            begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                ram_raddr    = cnt_reg + ADDR_W'(COLUMNS);
                ram_we       = pend_reg;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                pend_next    = 1'b1;
                wr_addr_next = cnt_reg;
                if (cnt_reg == ADDR_W'(COPY - 1))
                begin
                    state_next = S_SCROLL_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCROLL_END:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_addr_reg;
                ram_wdata  = ram_rdata;
                cnt_next   = ADDR_W'(COPY);
                state_next = S_FILL;
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_cell_next  = cell_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            attr_reg      <= RESET_ATTR;
            op_reg        <= OP_READ_OOR;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            attr_reg      <= attr_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        char_reg     <= char_next;
        addr_reg     <= addr_next;
        cell_reg     <= cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_cell_reg <= out_cell_next;
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row_out = out_row_reg;
    assign cursor_col_out = out_col_reg;
    assign cell_value     = out_cell_reg;

endmodule

// ===== hdl/text_console_cell_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Text-mode console engine: a ROWS x COLUMNS grid of attribute/character
// cells with a cursor, driven by put, backspace, clear and read commands.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | in_valid / in_stall | cmd, char_code, read_row, read_col
//   out     | output    | out_valid/out_stall | cursor_row_out, cursor_col_out,
//           |           |                     | cell_value
//   cfg     | input     | cfg_we              | cfg_wdata (text attribute)
//
// Put, newline, off-grid read and home backspace go from the queue through
// the execute and done states to out_valid; backspace and read also pass a
// blank write or registered RAM read state. A scroll copies ROWS-1 rows up,
// then blank-fills the bottom row, one cell per cycle; clear blank-fills
// every cell. After reset a clearing pass runs with in_stall high.
// A two-entry queue lets input transfers continue while a result waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tccw_pkg::cmd_t             cmd,
    input  tccw_pkg::char_t            char_code,
    input  logic [$clog2(ROWS)-1:0]    read_row,
    input  logic [$clog2(COLUMNS)-1:0] read_col,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [$clog2(ROWS)-1:0]    cursor_row_out,
    output logic [$clog2(COLUMNS)-1:0] cursor_col_out,
    output tccw_pkg::cell_t            cell_value,
    input  logic                       cfg_we,
    input  tccw_pkg::attr_t            cfg_wdata
);

    import tccw_pkg::*;

    localparam int ENTRY_W = OP_W + CHAR_W + $clog2(ROWS * COLUMNS);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;
    logic               init_busy;

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    tccw_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_not_empty    (q_not_empty),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .init_busy      (init_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_value     (cell_value)
    );

endmodule

// ===== sim/tb_text_console_cell_writer_core.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_core
// Self-checking bench for the text console cell writer. A shadow copy of the
// cell grid, cursor and text attribute predicts the cursor and cell word of
// every result. Directed commands cover the corners: reads at and past the
// grid edges, backspace at home, high character codes, newline followed by a
// backspace that crosses a row, and clear. Random phases follow, each after a
// text attribute write. Line-heavy phases force frequent scrolls, and
// prose phases force row wraps. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = ROWS * COLUMNS;
    localparam int ROW_W         = $clog2(ROWS);
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int SETTLE_CYCLES = CELLS + 16;
    localparam int TIMEOUT_NS    = 30_000_000;

    typedef enum {TRAFFIC_LINES, TRAFFIC_PROSE} traffic_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        cell_t            word;
    } console_view_t;

    class console_shadow;
        cell_t         grid [CELLS];
        int unsigned   row;
        int unsigned   col;
        attr_t         attr;
        console_view_t pending [$];
        int            mismatches;
        int            checked;
        int            puts;
        int            newlines;
        int            backspaces;
        int            home_backspaces;
        int            clears;
        int            reads;
        int            off_grid;
        int            wraps;
        int            scrolls;

        function new();
            attr = RESET_ATTR;
            blank_grid();
        endfunction

        function void blank_grid();
            for (int i = 0; i < CELLS; i++)
                grid[i] = {attr, BLANK_CODE};
            row = 0;
            col = 0;
        endfunction

        function void next_line();
            row++;
            if (row < ROWS)
                return;
            for (int i = 0; i < CELLS - COLUMNS; i++)
                grid[i] = grid[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                grid[i] = {attr, BLANK_CODE};
            row = ROWS - 1;
            scrolls++;
        endfunction

        function void note_command(cmd_t op, char_t code, logic [ROW_W-1:0] rr,
                                   logic [COL_W-1:0] rc);
            cell_t word;
            word = '0;
            case (op)
                CMD_PUT:
                begin
                    if (code == NEWLINE_CODE)
                    begin
                        newlines++;
                        col = 0;
                        next_line();
                    end
                    else
                    begin
                        puts++;
                        grid[row * COLUMNS + col] = {attr, code};
                        col++;
                        if (col >= COLUMNS)
                        begin
                            wraps++;
                            col = 0;
                            next_line();
                        end
                    end
                end
                CMD_BKSP:
                begin
                    backspaces++;
                    if (row == 0 && col == 0)
                        home_backspaces++;
                    else
                    begin
                        if (col == 0)
                        begin
                            row--;
                            col = COLUMNS - 1;
                        end
                        else
                            col--;
                        grid[row * COLUMNS + col] = {attr, BLANK_CODE};
                    end
                end
                CMD_CLEAR:
                begin
                    clears++;
                    blank_grid();
                end
                CMD_READ:
                begin
                    reads++;
                    if (rr < ROWS && rc < COLUMNS)
                        word = grid[rr * COLUMNS + rc];
                    else
                        off_grid++;
                end
                default:
                begin
                end
            endcase
            pending.push_back('{ROW_W'(row), COL_W'(col), word});
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_view(logic [ROW_W-1:0] r, logic [COL_W-1:0] c, cell_t w);
            console_view_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result: cursor (%0d,%0d) cell %h", r, c, w));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.row !== r || want.col !== c || want.word !== w)
                report($sformatf({"result %0d: got cursor (%0d,%0d) cell %h,",
                                  " expected (%0d,%0d) cell %h"},
                                 checked, r, c, w, want.row, want.col, want.word));
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    cmd_t             cmd       = CMD_PUT;
    char_t            char_code = '0;
    logic [ROW_W-1:0] read_row  = '0;
    logic [COL_W-1:0] read_col  = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [ROW_W-1:0] cursor_row_out;
    logic [COL_W-1:0] cursor_col_out;
    cell_t            cell_value;
    logic             cfg_we    = 1'b0;
    attr_t            cfg_wdata = '0;

    bit            gaps_on    = 1'b1;
    bit            stalls_on  = 1'b1;
    int            stall_left = 0;
    int            attr_writes = 0;
    console_shadow shadow = new();

    always #1 clk = ~clk;

    text_console_cell_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_row_out(cursor_row_out),
        .cursor_col_out(cursor_col_out),
        .cell_value    (cell_value),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // check each output transfer, then pick the stall for the next edge
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            shadow.check_view(cursor_row_out, cursor_col_out, cell_value);
        if (stall_left > 0)
            stall_left--;
        else if (stalls_on && $urandom_range(0, 3) == 0)
            stall_left = idle_span();
        out_stall <= (stall_left > 0);
    end

    task automatic send_item(cmd_t op, char_t code, logic [ROW_W-1:0] rr,
                             logic [COL_W-1:0] rc);
        int gap;
        gap = gaps_on ? idle_span() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        char_code <= code;
        read_row  <= rr;
        read_col  <= rc;
        do @(posedge clk); while (in_stall);
        shadow.note_command(op, code, rr, rc);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_attribute(attr_t value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow.attr = value;
        attr_writes++;
    endtask

    task automatic send_random(traffic_t mix);
        int               pick;
        int               put_cut;
        int               bksp_cut;
        char_t            code;
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        put_cut  = (mix == TRAFFIC_LINES) ? 110 : 165;
        bksp_cut = (mix == TRAFFIC_LINES) ? 140 : 175;
        pick = $urandom_range(0, 199);
        code = char_t'($urandom_range(0, 255));
        rr   = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        rc   = COL_W'($urandom_range(0, (1 << COL_W) - 1));
        if (pick < put_cut)
        begin
            if ($urandom_range(0, 99) < ((mix == TRAFFIC_LINES) ? 22 : 1))
                code = NEWLINE_CODE;
            send_item(CMD_PUT, code, rr, rc);
        end
        else if (pick < bksp_cut)
            send_item(CMD_BKSP, code, rr, rc);
        else if (pick == bksp_cut)
            send_item(CMD_CLEAR, code, rr, rc);
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                rr = ROW_W'(shadow.row);
                rc = (shadow.col == 0) ? '0 : COL_W'(shadow.col - 1);
            end
            else if (pick < 6)
            begin
                rr = ROW_W'(shadow.row);
                rc = COL_W'($urandom_range(0, COLUMNS - 1));
            end
            else if (pick < 8)
            begin
                rr = ROW_W'($urandom_range(0, ROWS - 1));
                rc = COL_W'($urandom_range(0, COLUMNS - 1));
            end
            send_item(CMD_READ, code, rr, rc);
        end
    endtask

    task automatic run_phase(attr_t value, traffic_t mix, int count, bit calm);
        set_attribute(value);
        gaps_on   = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
        stalls_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
        repeat (count) send_random(mix);
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("text_console_cell_writer_core test failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // grid corners, off-grid reads, puts, backspaces, newline and clear under the reset attribute
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd24, 7'd79);
        send_item(CMD_READ, 8'h00, 5'd25, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd31, 7'd127);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd80);
        send_item(CMD_BKSP, 8'h00, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h41, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'hFF, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h80, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h00, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h7F, 5'd0, 7'd0);
        for (int c = 0; c < 5; c++)
            send_item(CMD_READ, 8'h00, 5'd0, COL_W'(c));
        send_item(CMD_BKSP, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd4);
        send_item(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_item(CMD_BKSP, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd79);
        send_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);

        run_phase(8'hFF, TRAFFIC_LINES, 240, 1'b0);
        run_phase(8'h00, TRAFFIC_PROSE, 240, 1'b0);
        run_phase(attr_t'($urandom_range(1, 254)), TRAFFIC_LINES, 240, 1'b1);
        run_phase(8'hA5, TRAFFIC_PROSE, 240, 1'b0);
        run_phase(attr_t'($urandom_range(0, 255)), TRAFFIC_LINES, 240, 1'b0);
        run_phase(RESET_ATTR, TRAFFIC_PROSE, 240, 1'b0);
        run_phase(attr_t'($urandom_range(0, 255)), TRAFFIC_LINES, 240, 1'b0);
        wait_idle();

        $display({"covered %0d puts, %0d newlines, %0d backspaces (%0d at home),",
                  " %0d clears, %0d reads (%0d off grid)"},
                 shadow.puts, shadow.newlines, shadow.backspaces, shadow.home_backspaces,
                 shadow.clears, shadow.reads, shadow.off_grid);
        $display({"%0d row wraps, %0d scrolls, %0d attribute writes;",
                  " %0d results checked, %0d mismatches"},
                 shadow.wraps, shadow.scrolls, attr_writes, shadow.checked,
                 shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("text_console_cell_writer_core test passed");
        else
            $display("text_console_cell_writer_core test failed");
        $finish;
    end

endmodule
